// ===== design/drd_pkg.sv =====
// Package for the dirty range detector: opcodes, status codes, item and result
// layouts, the internal transaction passed to the compare stage, and helper functions.
// No dependencies; every design file except drd_stream_if imports it.
package drd_pkg;

	localparam int CNT_W   = 9;
	localparam int COMP_W  = 32;
	localparam int VEC_W   = 4 * COMP_W;
	localparam int REV_W   = 64;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CNT_W-1:0] MAX_VALUES_RST = 9'd256;
	localparam logic [PADDR_W-3:0] REG_MAX_VALUES = '0;

	typedef enum logic [1:0] {
		OP_ELEM  = 2'd0,
		OP_EMPTY = 2'd1,
		OP_CLEAR = 2'd2,
		OP_RSVD  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_MANY  = 2'd1,
		ST_NONFINITE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		TK_ELEM  = 2'd0,
		TK_EMPTY = 2'd1,
		TK_CLEAR = 2'd2
	} tok_kind_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [CNT_W-1:0]  count;
		logic [COMP_W-1:0] comp_x;
		logic [COMP_W-1:0] comp_y;
		logic [COMP_W-1:0] comp_z;
		logic [COMP_W-1:0] comp_w;
		logic [REV_W-1:0]  revision;
	} item_t;

	typedef struct packed {
		logic [7:0]       range_start;
		logic [CNT_W-1:0] range_length;
		logic             has_range;
		logic             full_upload;
		logic [1:0]       status;
		logic [REV_W-1:0] snapshot_revision;
		logic             done_res;
	} result_t;

	// Work handed from the accept stage to the compare stage.
	typedef struct packed {
		tok_kind_t        kind;
		logic             last;
		logic [1:0]       err;
		logic             full_mode;
		logic             cmp_en;
		logic             full_flag;
		logic [CNT_W-1:0] pos;
		logic [CNT_W-1:0] count;
		logic [VEC_W-1:0] comps;
		logic [REV_W-1:0] revision;
	} token_t;

	function automatic logic comp_nonfinite(input logic [COMP_W-1:0] c);
		return &c[30:23];
	endfunction

	// Bitwise equality, with +0 and -0 treated as equal.
	function automatic logic comp_equal(input logic [COMP_W-1:0] a,
			input logic [COMP_W-1:0] b);
		return (a == b) || (((a | b) & 32'h7FFF_FFFF) == '0);
	endfunction

	function automatic logic vec_equal(input logic [VEC_W-1:0] a,
			input logic [VEC_W-1:0] b);
		logic eq;
		eq = 1'b1;
		for (int k = 0; k < 4; k++) begin
			eq = eq & comp_equal(a[k*COMP_W +: COMP_W], b[k*COMP_W +: COMP_W]);
		end
		return eq;
	endfunction

endpackage

// ===== design/drd_stream_if.sv =====
// Valid/ready stream interface used for the item and result channels.
// The payload type is a parameter; the design instantiates it with drd_pkg types.
interface drd_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== design/drd_store.sv =====
// Two-bank vector store: one write port and one registered read port.
// Depends on drd_pkg for the vector width.
module drd_store #(
	parameter int MAX_ENTRIES = 256,
	parameter int AW = $clog2(2 * MAX_ENTRIES)
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [drd_pkg::VEC_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [drd_pkg::VEC_W-1:0] rd_data
);
	import drd_pkg::*;

	logic [VEC_W-1:0] mem [2*MAX_ENTRIES];
	logic [VEC_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// ===== design/drd_runs.sv =====
// Compare stage: checks each element against the stored vector, tracks the open
// run of changed indices and holds the result register. Depends on drd_pkg.
module drd_runs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      tok_valid,
	input  drd_pkg::token_t           tok,
	output logic                      tok_ready,
	input  logic [drd_pkg::VEC_W-1:0] stored_vec,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output drd_pkg::result_t          rsp_payload
);
	import drd_pkg::*;

	logic             tok_valid_s1;
	token_t           tok_s1;
	logic             run_open_q;
	logic [CNT_W-1:0] run_begin_q;
	logic             res_valid_q;
	result_t          res_q;

	logic             changed;
	logic             emit;
	logic             can_move;
	logic             run_open_d;
	logic [CNT_W-1:0] run_begin_d;
	logic [CNT_W-1:0] rb;
	result_t          res_d;

	assign changed = tok_s1.cmp_en && !vec_equal(tok_s1.comps, stored_vec);

	always_comb begin
		emit        = 1'b0;
		res_d       = '0;
		run_open_d  = run_open_q;
		run_begin_d = run_begin_q;
		rb          = run_open_q ? run_begin_q : tok_s1.pos;
		res_d.snapshot_revision = tok_s1.revision;
		unique case (tok_s1.kind)
			TK_CLEAR: begin
				run_open_d  = 1'b0;
				run_begin_d = '0;
			end
			TK_EMPTY: begin
				emit              = 1'b1;
				res_d.full_upload = tok_s1.full_flag;
				res_d.done_res    = 1'b1;
				run_open_d        = 1'b0;
				run_begin_d       = '0;
			end
			TK_ELEM: begin
				if (tok_s1.last) begin
					emit           = 1'b1;
					res_d.done_res = 1'b1;
					run_open_d     = 1'b0;
					run_begin_d    = '0;
					if (tok_s1.err != ST_OK) begin
						res_d.status = tok_s1.err;
					end else if (tok_s1.full_mode) begin
						res_d.range_length = tok_s1.count;
						res_d.has_range    = 1'b1;
						res_d.full_upload  = 1'b1;
					end else if (run_open_q || changed) begin
						res_d.range_start  = rb[7:0];
						res_d.range_length = tok_s1.pos + 9'd1 - rb;
						res_d.has_range    = 1'b1;
					end
				end else if (tok_s1.err == ST_OK && !tok_s1.full_mode) begin
					if (changed) begin
						if (!run_open_q) begin
							run_open_d  = 1'b1;
							run_begin_d = tok_s1.pos;
						end
					end else if (run_open_q) begin
						// The run ended at the previous index.
						emit               = 1'b1;
						run_open_d         = 1'b0;
						res_d.range_start  = run_begin_q[7:0];
						res_d.range_length = tok_s1.pos - run_begin_q;
						res_d.has_range    = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign can_move  = !tok_valid_s1 || !emit || !res_valid_q || rsp_ready;
	assign tok_ready = can_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_s1 <= 1'b0;
			run_open_q   <= 1'b0;
			run_begin_q  <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (can_move) begin
				tok_valid_s1 <= tok_valid;
			end
			if (tok_valid_s1 && can_move) begin
				run_open_q  <= run_open_d;
				run_begin_q <= run_begin_d;
			end
			if (tok_valid_s1 && emit && can_move) begin
				res_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_move && tok_valid) begin
			tok_s1 <= tok;
		end
		if (tok_valid_s1 && emit && can_move) begin
			res_q <= res_d;
		end
	end

	assign rsp_valid   = res_valid_q;
	assign rsp_payload = res_q;
endmodule

// ===== design/dirty_range_detector.sv =====
// Top level of the dirty range detector: accept stage, snapshot state, APB register.
// Depends on drd_pkg, drd_stream_if, drd_store and drd_runs.
//
// Usage: snapshot elements arrive on req, one four-component vector per transaction,
// in index order; opcode 1 ends an empty snapshot, opcode 2 clears the cache.
// Results leave on rsp: intermediate runs of changed indices (done_res 0) and one
// final result per snapshot (done_res 1) with the status, the last run or a full
// upload range. The limit max_values is written over APB at address 0.
// Path: an accepted item is registered in the compare stage, then its result in the
// result register that drives rsp. Throughput: one item per cycle unless rsp stalls.
// Each element costs one write of the other bank of the store and, outside full upload
// mode, one read of the current bank; the store has a port for each.
// Reset: max_values is 256, the cache is uninitialized, the store contents are
// undefined and need no clearing, since an entry is only read after the previous
// snapshot wrote it. When rsp stalls, the result register holds its transaction and
// the block keeps taking items until an item that produces a result waits in the
// compare stage; items that produce no result still flow through.
module dirty_range_detector #(
	parameter int MAX_ENTRIES = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	drd_stream_if.sink                  req,
	drd_stream_if.source                rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [drd_pkg::PADDR_W-1:0] paddr,
	input  logic [drd_pkg::PDATA_W-1:0] pwdata,
	output logic [drd_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import drd_pkg::*;

	localparam int AW = $clog2(2 * MAX_ENTRIES);

	logic [CNT_W-1:0] max_values_q;
	logic             bank_q;
	logic [CNT_W-1:0] stored_count_q;
	logic             initialized_q;
	logic [CNT_W-1:0] pos_q;
	logic [1:0]       error_q;

	item_t            item;
	logic             acc;
	logic             reg_hit;
	logic             too_many;
	logic             nonfin;
	logic [1:0]       err_new;
	logic             full_mode;
	logic             do_access;
	logic             last;
	logic             is_elem;
	logic             tok_valid;
	logic             tok_ready;
	token_t           tok;
	logic             wr_en;
	logic             rd_en;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    rd_addr;
	logic [VEC_W-1:0] vec;
	logic [VEC_W-1:0] stored_vec;

	// Configuration register.
	assign pready  = 1'b1;
	assign reg_hit = paddr[PADDR_W-1:2] == REG_MAX_VALUES;
	assign prdata  = reg_hit ? {{(PDATA_W-CNT_W){1'b0}}, max_values_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_values_q <= MAX_VALUES_RST;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			max_values_q <= pwdata[CNT_W-1:0];
		end
	end

	// Accept stage.
	assign item      = req.payload;
	assign req.ready = tok_ready;
	assign acc       = req.valid && req.ready;
	assign vec       = {item.comp_w, item.comp_z, item.comp_y, item.comp_x};

	assign too_many  = (item.count > max_values_q) || (32'(item.count) > MAX_ENTRIES);
	assign nonfin    = comp_nonfinite(item.comp_x) || comp_nonfinite(item.comp_y) ||
		comp_nonfinite(item.comp_z) || comp_nonfinite(item.comp_w);
	assign err_new   = too_many ? ST_TOO_MANY :
		((error_q == ST_OK && nonfin) ? ST_NONFINITE : error_q);
	assign full_mode = !initialized_q || (item.count != stored_count_q);
	assign do_access = (err_new == ST_OK) && (32'(pos_q) < MAX_ENTRIES);
	assign last      = ({1'b0, pos_q} + 10'd1) >= {1'b0, item.count};
	assign is_elem   = (op_t'(item.opcode) == OP_ELEM) && (item.count != '0);

	// Reads hit the current bank and writes the other one, so they never collide.
	assign wr_en   = acc && is_elem && do_access;
	assign rd_en   = wr_en && !full_mode;
	assign wr_addr = bank_q ? AW'(pos_q) : AW'(MAX_ENTRIES) + AW'(pos_q);
	assign rd_addr = bank_q ? AW'(MAX_ENTRIES) + AW'(pos_q) : AW'(pos_q);

	always_comb begin
		tok           = '0;
		tok_valid     = 1'b0;
		tok.pos       = pos_q;
		tok.count     = item.count;
		tok.comps     = vec;
		tok.revision  = item.revision;
		tok.last      = last;
		tok.err       = err_new;
		tok.full_mode = full_mode;
		tok.cmp_en    = do_access && !full_mode;
		tok.full_flag = !initialized_q || (stored_count_q != '0);
		unique case (op_t'(item.opcode))
			OP_ELEM: begin
				tok_valid = req.valid;
				tok.kind  = is_elem ? TK_ELEM : TK_EMPTY;
			end
			OP_EMPTY: begin
				tok_valid = req.valid;
				tok.kind  = TK_EMPTY;
			end
			OP_CLEAR: begin
				tok_valid = req.valid;
				tok.kind  = TK_CLEAR;
			end
			OP_RSVD: begin
				tok_valid = 1'b0;
				tok.kind  = TK_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q         <= 1'b0;
			stored_count_q <= '0;
			initialized_q  <= 1'b0;
			pos_q          <= '0;
			error_q        <= ST_OK;
		end else if (acc) begin
			unique case (op_t'(item.opcode))
				OP_CLEAR: begin
					pos_q          <= '0;
					error_q        <= ST_OK;
					initialized_q  <= 1'b0;
					stored_count_q <= '0;
				end
				OP_ELEM, OP_EMPTY: begin
					if (!is_elem) begin
						pos_q          <= '0;
						error_q        <= ST_OK;
						stored_count_q <= '0;
						initialized_q  <= 1'b1;
						bank_q         <= !bank_q;
					end else if (last) begin
						pos_q   <= '0;
						error_q <= ST_OK;
						if (err_new == ST_OK) begin
							bank_q         <= !bank_q;
							stored_count_q <= item.count;
							initialized_q  <= 1'b1;
						end
					end else begin
						pos_q   <= pos_q + 9'd1;
						error_q <= err_new;
					end
				end
				OP_RSVD: begin
				end
			endcase
		end
	end

	drd_store #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.AW         (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(vec),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(stored_vec)
	);

	drd_runs u_runs (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_valid  (tok_valid),
		.tok        (tok),
		.tok_ready  (tok_ready),
		.stored_vec (stored_vec),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_payload(rsp.payload)
	);

	a_count_needs_init: assert property (@(posedge clk) disable iff (!arst_n)
		stored_count_q != '0 |-> initialized_q)
		else $error("stored count is nonzero while the cache is uninitialized");

	a_error_no_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.payload.status != ST_OK |->
			!rsp.payload.has_range && !rsp.payload.full_upload && rsp.payload.done_res)
		else $error("error result carries a range");

	a_partial_is_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.payload.done_res |->
			rsp.payload.has_range && rsp.payload.range_length != '0 &&
			!rsp.payload.full_upload)
		else $error("intermediate result without a nonempty run");

	a_clear_drops_init: assert property (@(posedge clk) disable iff (!arst_n)
		acc && op_t'(item.opcode) == OP_CLEAR |=> !initialized_q && pos_q == '0)
		else $error("clear did not reset the cache state");
endmodule
